[rtl/ppsd_pkg.sv]
// Package for the pace pattern sync sample dropper.
// Holds the sequencer state type, register indexes and field helpers.
// No dependencies.
`default_nettype none
package ppsd_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned PaceW   = 12;
  localparam int unsigned PackW   = 48;
  localparam int unsigned CountW  = 3;
  localparam int unsigned RepW    = 5;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned IdxW    = 32;
  localparam int unsigned ThrW    = PaceW + RepW;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PACE_SUM     = 3'd0,
    CFG_PACE_COUNT   = 3'd1,
    CFG_PACE_LENGTHS = 3'd2,
    CFG_PACE_STARTS  = 3'd3,
    CFG_COMPARE_MODE = 3'd4,
    CFG_REPETITIONS  = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_RD_CUR,
    ST_RD_PREV,
    ST_CHECK,
    ST_DIV,
    ST_DECIDE,
    ST_EMIT
  } state_e;

  // Pace entry i of a packed register; entries past the fourth read as zero.
  function automatic logic [PaceW-1:0] pace_entry(input logic [PackW-1:0] r,
                                                  input logic [CountW-1:0] i);
    logic [PaceW-1:0] v;
    v = '0;
    if (i < CountW'(4)) begin
      v = r[PaceW*i[1:0] +: PaceW];
    end
    return v;
  endfunction

endpackage
`default_nettype wire

[rtl/ppsd_ram.sv]
// Generic single-port synchronous RAM with registered read data.
// Standalone, no dependencies.
`default_nettype none
module ppsd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule
`default_nettype wire

[rtl/pace_pattern_sync_sample_dropper.sv]
// Top level of the pace pattern sync sample dropper.
// Uses ppsd_pkg and two ppsd_ram history memories.
//
// Channel    Direction  Contents
// s_axis     in         tdata = left_sample, right_sample
// m_axis     out        tdata = left_out, right_out; tuser = locked
// cfg        in         write enable, register index, write data
//
// Before lock an item is written to history; once the stored count reaches window length
// times repetitions, each position tested is read as current then previous entry through
// the one read port of each history RAM. After lock an item goes straight to the output or,
// if its window position is needed, through the 32-step bit-serial remainder unit first.
// History RAMs are not cleared; entries at or past the fill count read as zero.
// A new word is taken while a finished word still waits on m_axis; a stalled m_axis
// holds the next item in its last cycle until the output register frees up.
`default_nettype none
module pace_pattern_sync_sample_dropper #(
  parameter int unsigned HISTORY_DEPTH = 1024,
  parameter int unsigned MAX_PACES     = 4
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [31:0]                  s_axis_tdata,  // left_sample, right_sample
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output logic [31:0]                       m_axis_tdata,  // left_out, right_out
  output logic [0:0]                        m_axis_tuser,  // locked
  input  wire logic                         cfg_we_i,
  input  wire logic [ppsd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [ppsd_pkg::PackW-1:0]   cfg_wdata_i
);
  import ppsd_pkg::*;

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned FW = AW + 1;
  localparam int unsigned LW = (AW > PaceW) ? AW : PaceW;
  localparam int unsigned CW = $clog2(IdxW);

  // Configuration registers.
  logic [PaceW-1:0]  win_len_q;
  logic [CountW-1:0] pace_count_q;
  logic [PackW-1:0]  pace_lengths_q, pace_starts_q;
  logic              compare_mode_q;
  logic [RepW-1:0]   repetitions_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q      <= PaceW'(1);
      pace_count_q   <= CountW'(1);
      pace_lengths_q <= '0;
      pace_starts_q  <= '0;
      compare_mode_q <= 1'b0;
      repetitions_q  <= RepW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PACE_SUM:     win_len_q      <= cfg_wdata_i[PaceW-1:0];
        CFG_PACE_COUNT:   pace_count_q   <= cfg_wdata_i[CountW-1:0];
        CFG_PACE_LENGTHS: pace_lengths_q <= cfg_wdata_i;
        CFG_PACE_STARTS:  pace_starts_q  <= cfg_wdata_i;
        CFG_COMPARE_MODE: compare_mode_q <= cfg_wdata_i[0];
        CFG_REPETITIONS:  repetitions_q  <= cfg_wdata_i[RepW-1:0];
        default: ;
      endcase
    end
  end

  logic [CountW-1:0] paces;
  assign paces = ({1'b0, pace_count_q} > (CountW+1)'(MAX_PACES)) ?
                 CountW'(MAX_PACES) : pace_count_q;

  logic [ThrW-1:0] threshold;
  assign threshold = ThrW'(win_len_q) * ThrW'(repetitions_q);

  // Control state.
  state_e            state_q, state_d;
  logic [AW-1:0]     wp_q, wp_d;
  logic [FW-1:0]     fill_q, fill_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [IdxW-1:0]   off_q, off_d;
  logic              lock_q, lock_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic [CountW-1:0] k_q, k_d;
  logic [RepW-1:0]   r_q, r_d;
  logic              lok_q, lok_d, rok_q, rok_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              ovld_q, ovld_d;
  logic              rvld_q, rvld_d;

  // Payload.
  logic [SampleW-1:0] l_q, l_d, r_smp_q, r_smp_d;
  logic [SampleW-1:0] lcur_q, lcur_d, rcur_q, rcur_d;
  logic [PaceW-1:0]   rem_q, rem_d;
  logic [IdxW-1:0]    dvd_q, dvd_d;
  logic [31:0]        odata_q, odata_d;
  logic               olock_q, olock_d;

  // History memories.
  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [SampleW-1:0] l_rdata, r_rdata, l_dat, r_dat;

  ppsd_ram #(.WIDTH(SampleW), .DEPTH(HISTORY_DEPTH)) u_left_ram (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(l_q), .rdata_o(l_rdata)
  );
  ppsd_ram #(.WIDTH(SampleW), .DEPTH(HISTORY_DEPTH)) u_right_ram (
    .clk_i, .we_i(ram_we), .addr_i(ram_addr), .wdata_i(r_smp_q), .rdata_o(r_rdata)
  );

  // Entries never written read as zero.
  assign l_dat = rvld_q ? l_rdata : '0;
  assign r_dat = rvld_q ? r_rdata : '0;

  logic               full;
  logic [FW-1:0]      fill_inc;
  logic               lhit, rhit;
  logic [LW-1:0]      pos_sub;
  logic [PaceW:0]     trial;
  logic               hit_start;
  logic               out_free;

  assign full     = (fill_q == FW'(HISTORY_DEPTH));
  assign fill_inc = full ? fill_q : fill_q + FW'(1);
  assign lhit     = lcur_q == (compare_mode_q ? l_dat : '0);
  assign rhit     = rcur_q == (compare_mode_q ? r_dat : '0);
  assign pos_sub  = LW'(pos_q) - LW'(pace_entry(pace_lengths_q, k_q - CountW'(1)));
  assign trial    = {rem_q, dvd_q[IdxW-1]};
  assign out_free = !ovld_q || m_axis_tready;

  always_comb begin
    hit_start = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (CountW'(i) < paces &&
          rem_q == pace_entry(pace_starts_q, CountW'(i))) begin
        hit_start = 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    wp_d = wp_q;  fill_d = fill_q;  idx_d = idx_q;  off_d = off_q;
    lock_d = lock_q;  pos_d = pos_q;  k_d = k_q;  r_d = r_q;
    lok_d = lok_q;  rok_d = rok_q;  cnt_d = cnt_q;
    l_d = l_q;  r_smp_d = r_smp_q;  lcur_d = lcur_q;  rcur_d = rcur_q;
    rem_d = rem_q;  dvd_d = dvd_q;
    odata_d = odata_q;  olock_d = olock_q;
    ovld_d = ovld_q && !m_axis_tready;
    ram_we = 1'b0;
    ram_addr = pos_q;
    rvld_d = 1'b0;
    s_axis_tready = (state_q == ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          l_d     = s_axis_tdata[15:0];
          r_smp_d = s_axis_tdata[31:16];
          rem_d   = '0;
          dvd_d   = idx_q - off_q;
          cnt_d   = '0;
          if (!lock_q) begin
            state_d = ST_WRITE;
          end else if (idx_q > off_q && win_len_q != '0) begin
            state_d = ST_DIV;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_WRITE: begin
        ram_we   = 1'b1;
        ram_addr = wp_q;
        wp_d     = wp_q + AW'(1);
        fill_d   = fill_inc;
        pos_d    = wp_q;
        k_d      = paces;
        r_d      = '0;
        lok_d    = 1'b1;
        rok_d    = 1'b1;
        state_d  = ((ThrW+FW)'(fill_inc) >= (ThrW+FW)'(threshold)) ? ST_RD_CUR : ST_EMIT;
      end
      ST_RD_CUR: begin
        ram_addr = pos_q;
        rvld_d   = full || FW'(pos_q) < fill_q;
        state_d  = ST_RD_PREV;
      end
      ST_RD_PREV: begin
        lcur_d   = l_dat;
        rcur_d   = r_dat;
        ram_addr = pos_q - AW'(1);
        rvld_d   = full || FW'(ram_addr) < fill_q;
        state_d  = ST_CHECK;
      end
      ST_CHECK: begin
        lok_d = lok_q && lhit;
        rok_d = rok_q && rhit;
        if (!lok_d && !rok_d) begin
          state_d = ST_EMIT;
        end else if (paces == '0 || r_q == repetitions_q) begin
          lock_d  = 1'b1;
          off_d   = idx_q;
          state_d = ST_EMIT;
        end else begin
          pos_d = pos_sub[AW-1:0];
          if (k_q == CountW'(1)) begin
            k_d = paces;
            r_d = r_q + RepW'(1);
          end else begin
            k_d = k_q - CountW'(1);
          end
          state_d = ST_RD_CUR;
        end
      end
      ST_DIV: begin
        // One quotient bit per cycle; the remainder stays below the window length.
        if (trial >= {1'b0, win_len_q}) begin
          rem_d = PaceW'(trial - {1'b0, win_len_q});
        end else begin
          rem_d = trial[PaceW-1:0];
        end
        dvd_d = dvd_q << 1;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(IdxW - 1)) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (hit_start) begin
          idx_d   = idx_q + IdxW'(1);
          state_d = ST_IDLE;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ovld_d  = 1'b1;
          odata_d = {r_smp_q, l_q};
          olock_d = lock_q;
          idx_d   = idx_q + IdxW'(1);
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wp_q    <= '0;
      fill_q  <= '0;
      idx_q   <= '0;
      off_q   <= '0;
      lock_q  <= 1'b0;
      pos_q   <= '0;
      k_q     <= '0;
      r_q     <= '0;
      lok_q   <= 1'b0;
      rok_q   <= 1'b0;
      cnt_q   <= '0;
      ovld_q  <= 1'b0;
      rvld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      fill_q  <= fill_d;
      idx_q   <= idx_d;
      off_q   <= off_d;
      lock_q  <= lock_d;
      pos_q   <= pos_d;
      k_q     <= k_d;
      r_q     <= r_d;
      lok_q   <= lok_d;
      rok_q   <= rok_d;
      cnt_q   <= cnt_d;
      ovld_q  <= ovld_d;
      rvld_q  <= rvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    l_q     <= l_d;
    r_smp_q <= r_smp_d;
    lcur_q  <= lcur_d;
    rcur_q  <= rcur_d;
    rem_q   <= rem_d;
    dvd_q   <= dvd_d;
    odata_q <= odata_d;
    olock_q <= olock_d;
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = olock_q;

endmodule
`default_nettype wire

[rtl/ppsd_chk.sv]
// Port-level checker for the pace pattern sync sample dropper.
// Bound to the top level; needs no package.
`default_nettype none
module ppsd_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic [0:0]  m_axis_tuser
);

  logic seen_lock_q;

  // Once a word has gone out marked locked, the lock is never released.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_lock_q <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready && m_axis_tuser[0]) begin
      seen_lock_q <= 1'b1;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("output valid during reset");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken on consecutive cycles");

  a_lock_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && seen_lock_q |-> m_axis_tuser[0])
    else $error("lock dropped after being reported");

endmodule

bind pace_pattern_sync_sample_dropper ppsd_chk u_ppsd_chk (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);
`default_nettype wire

[bench/pace_pattern_sync_sample_dropper_tb.sv]
// Testbench for the pace pattern sync sample dropper: drives sample pairs and register
// writes, predicts lock and drop decisions in a scoreboard class and checks every word.
// Depends on ppsd_pkg and the pace_pattern_sync_sample_dropper top level.
`timescale 1ns / 1ps
module pace_pattern_sync_sample_dropper_tb;
  import ppsd_pkg::*;

  localparam int unsigned Depth = 1024;
  localparam int unsigned Mask  = Depth - 1;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic        locked;
  } kept_pair_t;

  class dropper_scoreboard;
    logic [11:0] win_len;
    logic [2:0]  pace_count;
    logic [47:0] pace_lengths;
    logic [47:0] pace_starts;
    logic        compare_mode;
    logic [4:0]  repetitions;
    logic [15:0] hist [2][Depth];
    logic [9:0]  wr_pos;
    int unsigned fill;
    logic [31:0] item_idx;
    logic [31:0] lock_off;
    bit          locked;
    kept_pair_t  kept_q[$];
    int unsigned errors;

    function void clear();
      win_len = 12'd1; pace_count = 3'd1; pace_lengths = '0; pace_starts = '0;
      compare_mode = 1'b0; repetitions = 5'd1;
      foreach (hist[c, i]) hist[c][i] = '0;
      wr_pos = '0; fill = 0; item_idx = '0; lock_off = '0; locked = 1'b0; errors = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [47:0] val);
      case (idx)
        CFG_PACE_SUM:     win_len = val[11:0];
        CFG_PACE_COUNT:   pace_count = val[2:0];
        CFG_PACE_LENGTHS: pace_lengths = val;
        CFG_PACE_STARTS:  pace_starts = val;
        CFG_COMPARE_MODE: compare_mode = val[0];
        CFG_REPETITIONS:  repetitions = val[4:0];
        default: ;
      endcase
    endfunction

    function int unsigned paces();
      return (pace_count > 4) ? 4 : pace_count;
    endfunction

    function int unsigned entry(logic [47:0] r, int unsigned i);
      return (i >= 4) ? 0 : r[12*i +: 12];
    endfunction

    function bit is_marker(int c, int unsigned pos);
      logic [15:0] want;
      want = compare_mode ? hist[c][(pos - 1) & Mask] : 16'd0;
      return hist[c][pos & Mask] == want;
    endfunction

    function bit pattern_hit(int c);
      int unsigned pos;
      int unsigned n;
      pos = (wr_pos - 1) & Mask;
      n = paces();
      if (fill < win_len * repetitions) return 0;
      if (!is_marker(c, pos)) return 0;
      for (int unsigned r = 0; r < repetitions; r++) begin
        for (int unsigned k = n; k > 0; k--) begin
          pos = (pos - entry(pace_lengths, k - 1)) & Mask;
          if (!is_marker(c, pos)) return 0;
        end
      end
      return 1;
    endfunction

    function bit drop_due();
      logic [31:0] win;
      if (win_len == 0 || item_idx <= lock_off) return 0;
      win = (item_idx - lock_off) % win_len;
      for (int unsigned i = 0; i < paces(); i++)
        if (win == entry(pace_starts, i)) return 1;
      return 0;
    endfunction

    function void note_pair(logic [15:0] l, logic [15:0] r);
      kept_pair_t p;
      if (locked && drop_due()) begin
        item_idx++;
        return;
      end
      if (!locked) begin
        hist[0][wr_pos] = l;
        hist[1][wr_pos] = r;
        wr_pos++;
        if (fill < Depth) fill++;
        if (pattern_hit(0) || pattern_hit(1)) begin
          locked = 1;
          lock_off = item_idx;
        end
      end
      p.left = l; p.right = r; p.locked = locked;
      kept_q.push_back(p);
      item_idx++;
    endfunction

    function void check_word(logic [31:0] data, logic user);
      kept_pair_t e;
      if (kept_q.size() == 0) begin
        $display("%0t: unexpected word data=%h user=%b", $time, data, user);
        errors++;
        return;
      end
      e = kept_q.pop_front();
      if (data[15:0] !== e.left) begin
        $display("%0t: left expected %h actual %h", $time, e.left, data[15:0]);
        errors++;
      end
      if (data[31:16] !== e.right) begin
        $display("%0t: right expected %h actual %h", $time, e.right, data[31:16]);
        errors++;
      end
      if (user !== e.locked) begin
        $display("%0t: locked expected %b actual %b", $time, e.locked, user);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [31:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_we_i = 0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [PackW-1:0]   cfg_wdata_i = '0;

  dropper_scoreboard sb = new();
  bit calm = 0;

  always #5 clk_i = ~clk_i;

  pace_pattern_sync_sample_dropper i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata, m_axis_tuser[0]);
    m_axis_tready <= calm || ($urandom_range(99) >= 7);
  end

  // Called in the step of a rising edge; returns in the step of the accepting edge.
  task automatic send_pair(logic [15:0] l, logic [15:0] r);
    if (!calm && $urandom_range(99) < 7) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {r, l};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_pair(l, r);
  endtask

  // The enable drops for one cycle between writes.
  task automatic write_reg(cfg_idx_e idx, logic [47:0] val);
    cfg_we_i    <= 1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    sb.set_reg(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  // Waits for every expected word, then lets the block finish a dropped pair.
  task automatic drain();
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    while (sb.kept_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  function automatic logic [47:0] starts_within(int unsigned sum);
    logic [47:0] v;
    for (int i = 0; i < 4; i++) v[12*i +: 12] = 12'($urandom_range(sum - 1));
    return v;
  endfunction

  initial begin
    #100ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    int unsigned sum;
    int unsigned t;
    logic [15:0] prev;
    sb.clear();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // A threshold far above the history size keeps the block searching without lock.
    write_reg(CFG_PACE_SUM, 48'd4095);
    write_reg(CFG_REPETITIONS, 48'd16);
    write_reg(CFG_PACE_COUNT, 48'd4);
    write_reg(CFG_PACE_LENGTHS, 48'hFFF_FFF_FFF_FFF);
    write_reg(CFG_PACE_STARTS, 48'hFFF_FFF_FFF_FFF);
    write_reg(CFG_COMPARE_MODE, 48'd0);
    send_pair(16'h0000, 16'h0000);
    send_pair(16'hFFFF, 16'hFFFF);
    send_pair(16'h0000, 16'hFFFF);
    send_pair(16'hFFFF, 16'h0000);
    send_pair(16'h8000, 16'h7FFF);
    send_pair(16'h0001, 16'hFFFE);
    send_pair(16'h5555, 16'hAAAA);
    send_pair(16'h5555, 16'h5555);
    calm = 1;
    repeat (100) send_pair(16'($urandom), 16'($urandom));
    calm = 0;
    repeat (100) send_pair(16'($urandom), ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom));
    drain();

    // Equal-neighbor markers with a pattern still too long for the history.
    write_reg(CFG_COMPARE_MODE, 48'd1);
    write_reg(CFG_REPETITIONS, 48'($urandom_range(31, 26)));
    write_reg(CFG_PACE_SUM, 48'($urandom_range(4095, 40)));
    write_reg(CFG_PACE_LENGTHS, 48'({$urandom, $urandom}));
    write_reg(CFG_PACE_COUNT, 48'($urandom_range(7)));
    prev = '0;
    repeat (150) begin
      prev = ($urandom_range(3) == 0) ? prev : 16'($urandom);
      send_pair(prev, ($urandom_range(3) == 0) ? prev : 16'($urandom));
    end
    drain();

    // Zero markers every 12 samples at offsets 0, 3 and 7 on the right channel.
    write_reg(CFG_COMPARE_MODE, 48'd0);
    write_reg(CFG_PACE_SUM, 48'd12);
    write_reg(CFG_PACE_COUNT, 48'd3);
    write_reg(CFG_PACE_LENGTHS, {12'($urandom), 12'd5, 12'd4, 12'd3});
    write_reg(CFG_REPETITIONS, 48'd2);
    write_reg(CFG_PACE_STARTS, 48'h000_009_005_000);
    t = 0;
    while (!sb.locked && t < 300) begin
      send_pair(16'($urandom) | 16'h1,
                (t % 12 == 0 || t % 12 == 3 || t % 12 == 7) ? 16'd0 :
                (16'($urandom) | 16'h1));
      t++;
    end
    repeat (60) send_pair(16'($urandom), 16'($urandom));
    drain();

    // After lock: several window settings, with the extremes.
    for (int ph = 0; ph < 6; ph++) begin
      sum = $urandom_range(16, 2);
      write_reg(CFG_PACE_SUM, 48'(sum));
      write_reg(CFG_PACE_STARTS, starts_within(sum));
      write_reg(CFG_PACE_COUNT, 48'($urandom_range(4, 1)));
      case (ph)
        1: write_reg(CFG_PACE_SUM, 48'd0);
        2: write_reg(CFG_PACE_COUNT, 48'd0);
        3: begin
          write_reg(CFG_PACE_SUM, 48'd4095);
          write_reg(CFG_PACE_STARTS, 48'({$urandom, $urandom}));
          write_reg(CFG_PACE_COUNT, 48'd7);
        end
        4: begin
          write_reg(CFG_REPETITIONS, 48'd0);
          write_reg(CFG_COMPARE_MODE, 48'd1);
          write_reg(CFG_PACE_COUNT, 48'd5);
        end
        default: ;
      endcase
      repeat (100) send_pair(16'($urandom), 16'($urandom));
      drain();
    end

    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
